FILE: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/bmc_pkg.sv
package bmc_pkg;
  // field widths
  localparam int MOD_BITS = 20;
  localparam int N_BITS   = 60;
  // divider datapath width: widest dividend is n or a modular product
  localparam int DIV_W    = (N_BITS > 2 * MOD_BITS) ? N_BITS : 2 * MOD_BITS;
  localparam int DCNT_W   = $clog2(DIV_W + 1);
  localparam int RND_W    = $clog2(N_BITS + 1);
  // signed width of the extended euclid coefficients
  localparam int COEF_W   = MOD_BITS + 2;
  localparam int MEM_DEPTH = 1 << MOD_BITS;
endpackage

FILE: hdl/binomial_mod_composite.sv
// binomial_mod_composite: C(n,m) mod modulus by the extended lucas method.
// input channel: in_valid/in_ready carries n_value, m_value and modulus.
// output channel: out_valid/out_ready carries residue.
// one request is worked at a time; in_ready is high only while idle, and a
// result is held on residue until out_ready takes it, then the next request
// can be accepted in the following cycle.
// m > n or a modulus of zero or one goes straight to the output state. otherwise
// the modulus is factored by trial division, and for every prime power pk a
// prefix product table of pk entries is built, one multiply plus a
// shift-subtract reduction per entry not divisible by p. each p-free
// factorial takes up to N_BITS rounds, each round a modular power over the
// bits of x/pk (up to two modular multiplies per bit). all modular multiplies
// go through one multiplier and all divisions through one restoring divider
// that retires one quotient bit per cycle, so a new request is not taken
// until the last result has been taken.
// reset returns the sequencer to idle and drops out_valid; the prefix table
// needs no clearing since each one is fully rewritten before it is read.
`include "assert_macros.svh"

module binomial_mod_composite (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bmc_pkg::N_BITS-1:0]    n_value,
  input  logic [bmc_pkg::N_BITS-1:0]    m_value,
  input  logic [bmc_pkg::MOD_BITS-1:0]  modulus,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bmc_pkg::MOD_BITS-1:0]  residue
);

  typedef enum logic [5:0] {
    S_IDLE, S_OUT, S_FCHK, S_FDIV, S_FDIVD, S_FNEXT, S_FLAST,
    S_BSTART, S_TSTEP, S_TMD,
    S_FFINIT, S_FFCHK, S_FFD1, S_FFP, S_FFM1, S_FFM2, S_FFD2, S_FFEND,
    S_BI2, S_BM1, S_BI3, S_BM2, S_BP, S_BM3,
    S_CD1, S_CM1, S_CD2, S_CI, S_CM2,
    S_PWCHK, S_PWM1, S_PWSQ, S_PWM2,
    S_MMMUL, S_MMDIV, S_MMEND,
    S_IVCHK, S_IVD, S_IVS, S_IVEND,
    S_DIV
  } state_t;

  state_t state, ret_div, ret_mm, ret_pw, ret_inv, ret_b;

  // operands and factoring
  logic [bmc_pkg::N_BITS-1:0]   n, m, x, e;
  logic [bmc_pkg::MOD_BITS-1:0] md, rest, d, pk, p, acc;
  // shared divider
  logic [bmc_pkg::DIV_W-1:0]    div_num;
  logic [bmc_pkg::MOD_BITS-1:0] div_rem, div_den;
  logic [bmc_pkg::DCNT_W-1:0]   div_cnt;
  // shared modular multiplier
  logic [bmc_pkg::MOD_BITS-1:0]   mm_a, mm_b, mm_mod, mm_res;
  logic [2*bmc_pkg::MOD_BITS-1:0] mm_prod;
  // modular power
  logic [bmc_pkg::MOD_BITS-1:0] pw_base, pw_res;
  logic [bmc_pkg::N_BITS-1:0]   pw_exp;
  // modular inverse
  logic [bmc_pkg::MOD_BITS-1:0]      r0, r1, iv_q, inv_res;
  logic signed [bmc_pkg::COEF_W-1:0] s0, s1;
  // prefix table build and factorials
  logic [bmc_pkg::MOD_BITS-1:0] idx, jmod, prev, full, ff_r, f1, f2, f3, r_pk, other, t;
  logic [bmc_pkg::RND_W-1:0]    rnd;
  logic [1:0]                   ff_sel;
  // prefix product memory
  logic [bmc_pkg::MOD_BITS-1:0] mem [bmc_pkg::MEM_DEPTH];
  logic                         mem_we;
  logic [bmc_pkg::MOD_BITS-1:0] mem_wa, mem_wd, mem_q;

  // divider step
  logic [bmc_pkg::MOD_BITS:0] dsh;
  logic                       dge;
  assign dsh = {div_rem, div_num[bmc_pkg::DIV_W-1]};
  assign dge = dsh >= {1'b0, div_den};

  // trial divisor bound
  logic [2*bmc_pkg::MOD_BITS-1:0] dsq;
  assign dsq = d * d;

  // euclid coefficient update
  logic signed [bmc_pkg::COEF_W+bmc_pkg::MOD_BITS:0] iv_prod;
  logic signed [bmc_pkg::COEF_W-1:0] pk_s;
  assign iv_prod = $signed({1'b0, iv_q}) * s1;
  assign pk_s    = $signed({2'b00, pk});

  // accumulation of the chinese remainder sum
  logic [bmc_pkg::MOD_BITS:0] acc_sum;
  assign acc_sum = {1'b0, acc} + {1'b0, mm_res};

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign residue   = acc;

  // prefix table write port, driven by the table build states
  assign mem_we = (state == S_BSTART) || (state == S_TMD) ||
                  (state == S_TSTEP && idx != pk && jmod == '0);
  assign mem_wa = (state == S_BSTART) ? '0 : idx;
  assign mem_wd = (state == S_BSTART) ? bmc_pkg::MOD_BITS'(1) :
                  (state == S_TMD) ? mm_res : prev;

  // prefix table
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[r_pk];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            n    <= n_value;
            m    <= m_value;
            md   <= modulus;
            rest <= modulus;
            d    <= bmc_pkg::MOD_BITS'(2);
            acc  <= '0;
            if (modulus <= bmc_pkg::MOD_BITS'(1) || m_value > n_value) state <= S_OUT;
            else state <= S_FCHK;
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end

        // trial division over the modulus
        S_FCHK: begin
          pk <= bmc_pkg::MOD_BITS'(1);
          if (dsq > {{bmc_pkg::MOD_BITS{1'b0}}, rest} || rest <= bmc_pkg::MOD_BITS'(1))
            state <= S_FLAST;
          else state <= S_FDIV;
        end
        S_FDIV: begin
          div_num <= bmc_pkg::DIV_W'(rest) << (bmc_pkg::DIV_W - bmc_pkg::MOD_BITS);
          div_rem <= '0;
          div_den <= d;
          div_cnt <= bmc_pkg::DCNT_W'(bmc_pkg::MOD_BITS);
          ret_div <= S_FDIVD;
          state   <= S_DIV;
        end
        S_FDIVD: begin
          if (div_rem == '0) begin
            pk    <= bmc_pkg::MOD_BITS'(pk * d);
            rest  <= div_num[bmc_pkg::MOD_BITS-1:0];
            state <= S_FDIV;
          end else if (pk > bmc_pkg::MOD_BITS'(1)) begin
            p     <= d;
            ret_b <= S_FNEXT;
            state <= S_BSTART;
          end else begin
            d     <= d + bmc_pkg::MOD_BITS'(1);
            state <= S_FCHK;
          end
        end
        S_FNEXT: begin
          d     <= d + bmc_pkg::MOD_BITS'(1);
          state <= S_FCHK;
        end
        S_FLAST: begin
          if (rest > bmc_pkg::MOD_BITS'(1)) begin
            p     <= rest;
            pk    <= rest;
            ret_b <= S_OUT;
            state <= S_BSTART;
          end else state <= S_OUT;
        end

        // prefix products of the p-free values below pk
        S_BSTART: begin
          prev   <= bmc_pkg::MOD_BITS'(1);
          idx    <= bmc_pkg::MOD_BITS'(1);
          jmod   <= bmc_pkg::MOD_BITS'(1);
          state  <= S_TSTEP;
        end
        S_TSTEP: begin
          if (idx == pk) begin
            full   <= prev;
            ff_sel <= 2'd0;
            x      <= n;
            e      <= '0;
            state  <= S_FFINIT;
          end else if (jmod == '0) begin
            idx    <= idx + bmc_pkg::MOD_BITS'(1);
            jmod   <= (jmod + bmc_pkg::MOD_BITS'(1) == p) ? '0 : jmod + bmc_pkg::MOD_BITS'(1);
          end else begin
            mm_a   <= prev;
            mm_b   <= idx;
            mm_mod <= pk;
            ret_mm <= S_TMD;
            state  <= S_MMMUL;
          end
        end
        S_TMD: begin
          prev   <= mm_res;
          idx    <= idx + bmc_pkg::MOD_BITS'(1);
          jmod   <= (jmod + bmc_pkg::MOD_BITS'(1) == p) ? '0 : jmod + bmc_pkg::MOD_BITS'(1);
          state  <= S_TSTEP;
        end

        // p-free factorial of x, with the exponent of p gathered alongside
        S_FFINIT: begin
          ff_r  <= bmc_pkg::MOD_BITS'(1);
          rnd   <= '0;
          state <= S_FFCHK;
        end
        S_FFCHK: begin
          if (rnd == bmc_pkg::RND_W'(bmc_pkg::N_BITS) || x == '0) state <= S_FFEND;
          else begin
            div_num <= bmc_pkg::DIV_W'(x) << (bmc_pkg::DIV_W - bmc_pkg::N_BITS);
            div_rem <= '0;
            div_den <= pk;
            div_cnt <= bmc_pkg::DCNT_W'(bmc_pkg::N_BITS);
            ret_div <= S_FFD1;
            state   <= S_DIV;
          end
        end
        S_FFD1: begin
          r_pk    <= div_rem;
          pw_base <= full;
          pw_exp  <= div_num[bmc_pkg::N_BITS-1:0];
          pw_res  <= bmc_pkg::MOD_BITS'(1);
          ret_pw  <= S_FFP;
          state   <= S_PWCHK;
        end
        S_FFP: begin
          mm_a   <= ff_r;
          mm_b   <= pw_res;
          mm_mod <= pk;
          ret_mm <= S_FFM1;
          state  <= S_MMMUL;
        end
        S_FFM1: begin
          mm_a   <= mm_res;
          mm_b   <= mem_q;
          mm_mod <= pk;
          ret_mm <= S_FFM2;
          state  <= S_MMMUL;
        end
        S_FFM2: begin
          ff_r    <= mm_res;
          div_num <= bmc_pkg::DIV_W'(x) << (bmc_pkg::DIV_W - bmc_pkg::N_BITS);
          div_rem <= '0;
          div_den <= p;
          div_cnt <= bmc_pkg::DCNT_W'(bmc_pkg::N_BITS);
          ret_div <= S_FFD2;
          state   <= S_DIV;
        end
        S_FFD2: begin
          x     <= div_num[bmc_pkg::N_BITS-1:0];
          e     <= (ff_sel == 2'd0) ? e + div_num[bmc_pkg::N_BITS-1:0]
                                    : e - div_num[bmc_pkg::N_BITS-1:0];
          rnd   <= rnd + bmc_pkg::RND_W'(1);
          state <= S_FFCHK;
        end
        S_FFEND: begin
          case (ff_sel)
            2'd0: begin
              f1     <= ff_r;
              x      <= m;
              ff_sel <= 2'd1;
              state  <= S_FFINIT;
            end
            2'd1: begin
              f2     <= ff_r;
              x      <= n - m;
              ff_sel <= 2'd2;
              state  <= S_FFINIT;
            end
            default: begin
              f3      <= ff_r;
              r0      <= pk;
              r1      <= f2;
              s0      <= '0;
              s1      <= bmc_pkg::COEF_W'(1);
              ret_inv <= S_BI2;
              state   <= S_IVCHK;
            end
          endcase
        end

        // combine factorials and the leftover power of p
        S_BI2: begin
          mm_a   <= f1;
          mm_b   <= inv_res;
          mm_mod <= pk;
          ret_mm <= S_BM1;
          state  <= S_MMMUL;
        end
        S_BM1: begin
          f1      <= mm_res;
          r0      <= pk;
          r1      <= f3;
          s0      <= '0;
          s1      <= bmc_pkg::COEF_W'(1);
          ret_inv <= S_BI3;
          state   <= S_IVCHK;
        end
        S_BI3: begin
          mm_a   <= f1;
          mm_b   <= inv_res;
          mm_mod <= pk;
          ret_mm <= S_BM2;
          state  <= S_MMMUL;
        end
        S_BM2: begin
          f1      <= mm_res;
          pw_base <= (p == pk) ? '0 : p;
          pw_exp  <= e;
          pw_res  <= bmc_pkg::MOD_BITS'(1);
          ret_pw  <= S_BP;
          state   <= S_PWCHK;
        end
        S_BP: begin
          mm_a   <= f1;
          mm_b   <= pw_res;
          mm_mod <= pk;
          ret_mm <= S_BM3;
          state  <= S_MMMUL;
        end
        S_BM3: begin
          f1      <= mm_res;
          div_num <= bmc_pkg::DIV_W'(md) << (bmc_pkg::DIV_W - bmc_pkg::MOD_BITS);
          div_rem <= '0;
          div_den <= pk;
          div_cnt <= bmc_pkg::DCNT_W'(bmc_pkg::MOD_BITS);
          ret_div <= S_CD1;
          state   <= S_DIV;
        end

        // chinese remainder step
        S_CD1: begin
          other  <= div_num[bmc_pkg::MOD_BITS-1:0];
          mm_a   <= f1;
          mm_b   <= div_num[bmc_pkg::MOD_BITS-1:0];
          mm_mod <= md;
          ret_mm <= S_CM1;
          state  <= S_MMMUL;
        end
        S_CM1: begin
          t       <= mm_res;
          div_num <= bmc_pkg::DIV_W'(other) << (bmc_pkg::DIV_W - bmc_pkg::MOD_BITS);
          div_rem <= '0;
          div_den <= pk;
          div_cnt <= bmc_pkg::DCNT_W'(bmc_pkg::MOD_BITS);
          ret_div <= S_CD2;
          state   <= S_DIV;
        end
        S_CD2: begin
          r0      <= pk;
          r1      <= div_rem;
          s0      <= '0;
          s1      <= bmc_pkg::COEF_W'(1);
          ret_inv <= S_CI;
          state   <= S_IVCHK;
        end
        S_CI: begin
          mm_a   <= t;
          mm_b   <= inv_res;
          mm_mod <= md;
          ret_mm <= S_CM2;
          state  <= S_MMMUL;
        end
        S_CM2: begin
          acc   <= (acc_sum >= {1'b0, md}) ? bmc_pkg::MOD_BITS'(acc_sum - {1'b0, md})
                                           : acc_sum[bmc_pkg::MOD_BITS-1:0];
          state <= ret_b;
        end

        // square and multiply, exponent bits from the bottom
        S_PWCHK: begin
          if (pw_exp == '0) state <= ret_pw;
          else if (pw_exp[0]) begin
            mm_a   <= pw_res;
            mm_b   <= pw_base;
            mm_mod <= pk;
            ret_mm <= S_PWM1;
            state  <= S_MMMUL;
          end else state <= S_PWSQ;
        end
        S_PWM1: begin
          pw_res <= mm_res;
          state  <= S_PWSQ;
        end
        S_PWSQ: begin
          mm_a   <= pw_base;
          mm_b   <= pw_base;
          mm_mod <= pk;
          ret_mm <= S_PWM2;
          state  <= S_MMMUL;
        end
        S_PWM2: begin
          pw_base <= mm_res;
          pw_exp  <= pw_exp >> 1;
          state   <= S_PWCHK;
        end

        // modular multiply: product then reduction in the divider
        S_MMMUL: begin
          mm_prod <= mm_a * mm_b;
          state   <= S_MMDIV;
        end
        S_MMDIV: begin
          div_num <= bmc_pkg::DIV_W'(mm_prod) << (bmc_pkg::DIV_W - 2 * bmc_pkg::MOD_BITS);
          div_rem <= '0;
          div_den <= mm_mod;
          div_cnt <= bmc_pkg::DCNT_W'(2 * bmc_pkg::MOD_BITS);
          ret_div <= S_MMEND;
          state   <= S_DIV;
        end
        S_MMEND: begin
          mm_res <= div_rem;
          state  <= ret_mm;
        end

        // extended euclid for the inverse modulo pk
        S_IVCHK: begin
          if (r1 == '0) state <= S_IVEND;
          else begin
            div_num <= bmc_pkg::DIV_W'(r0) << (bmc_pkg::DIV_W - bmc_pkg::MOD_BITS);
            div_rem <= '0;
            div_den <= r1;
            div_cnt <= bmc_pkg::DCNT_W'(bmc_pkg::MOD_BITS);
            ret_div <= S_IVD;
            state   <= S_DIV;
          end
        end
        S_IVD: begin
          iv_q  <= div_num[bmc_pkg::MOD_BITS-1:0];
          r0    <= r1;
          r1    <= div_rem;
          state <= S_IVS;
        end
        S_IVS: begin
          s0    <= s1;
          s1    <= s0 - $signed(iv_prod[bmc_pkg::COEF_W-1:0]);
          state <= S_IVCHK;
        end
        S_IVEND: begin
          if (s0 < 0) inv_res <= bmc_pkg::MOD_BITS'(s0 + pk_s);
          else if (s0 >= pk_s) inv_res <= bmc_pkg::MOD_BITS'(s0 - pk_s);
          else inv_res <= bmc_pkg::MOD_BITS'(s0);
          state <= ret_inv;
        end

        // restoring divider, one quotient bit per cycle
        S_DIV: begin
          div_rem <= dge ? bmc_pkg::MOD_BITS'(dsh - {1'b0, div_den})
                         : dsh[bmc_pkg::MOD_BITS-1:0];
          div_num <= {div_num[bmc_pkg::DIV_W-2:0], dge};
          div_cnt <= div_cnt - bmc_pkg::DCNT_W'(1);
          if (div_cnt == bmc_pkg::DCNT_W'(1)) state <= ret_div;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_one_side, in_ready, !out_valid)
  `ASSERT_IMPL(a_div_den, state == S_DIV, div_den != '0)
  `ASSERT_IMPL(a_res_range, out_valid, residue == '0 || residue < md)
  `ASSERT_NEXT(a_out_done, out_valid && out_ready, in_ready)

endmodule

FILE: tb/tb_binomial_mod_composite.sv
module tb_binomial_mod_composite;

  localparam int N_BITS         = bmc_pkg::N_BITS;
  localparam int MOD_BITS       = bmc_pkg::MOD_BITS;
  localparam int WATCHDOG_LIMIT = 4000000;
  localparam int SETTLE_CYCLES  = 64;

  typedef struct {
    logic [N_BITS-1:0]   n;
    logic [N_BITS-1:0]   m;
    logic [MOD_BITS-1:0] md;
    bit                  drain;
  } binom_req_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [N_BITS-1:0]   n_value;
  logic [N_BITS-1:0]   m_value;
  logic [MOD_BITS-1:0] modulus;
  logic                out_valid;
  logic                out_ready;
  logic [MOD_BITS-1:0] residue;

  binom_req_t          pending_reqs[$];
  logic [MOD_BITS-1:0] expected_residues[$];
  int                  mismatch_count;
  int                  accepted_reqs;
  int                  accepted_results;
  int                  quiet_cycles;
  int unsigned         prefix_tab[];

  binomial_mod_composite dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .n_value(n_value), .m_value(m_value), .modulus(modulus),
    .out_valid(out_valid), .out_ready(out_ready), .residue(residue)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // modular arithmetic for the predictor; all moduli and residues stay below 2^20
  function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                              longint unsigned md);
    longint unsigned r;
    r = 1 % md;
    b = b % md;
    while (e != 0) begin
      if (e[0]) r = r * b % md;
      b = b * b % md;
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic longint unsigned inv_mod(longint unsigned a, longint unsigned md);
    longint r0, r1, s0, s1, q, t, v;
    r0 = md;
    r1 = a % md;
    s0 = 0;
    s1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      t = r0 - q * r1; r0 = r1; r1 = t;
      t = s0 - q * s1; s0 = s1; s1 = t;
    end
    v = s0 % longint'(md);
    if (v < 0) v += md;
    return longint'(v);
  endfunction

  // factorial of n with all factors of p removed, modulo pk
  function automatic longint unsigned pfree_fact(longint unsigned n, longint unsigned p,
                                                 longint unsigned pk);
    longint unsigned r, full;
    full = prefix_tab[pk-1];
    r = 1 % pk;
    for (int rnd = 0; rnd < N_BITS && n != 0; rnd++) begin
      r = r * pow_mod(full, n / pk, pk) % pk;
      r = r * prefix_tab[n % pk] % pk;
      n = n / p;
    end
    return r;
  endfunction

  function automatic longint unsigned p_excess(longint unsigned n, longint unsigned p);
    longint unsigned c;
    c = 0;
    while (n != 0) begin
      n = n / p;
      c += n;
    end
    return c;
  endfunction

  function automatic longint unsigned binom_prime_pow(longint unsigned n, longint unsigned m,
                                                      longint unsigned p, longint unsigned pk);
    longint unsigned fn, fm, fd, e;
    prefix_tab = new[pk];
    prefix_tab[0] = 32'(1 % pk);
    for (longint unsigned i = 1; i < pk; i++)
      prefix_tab[i] = 32'(longint'(prefix_tab[i-1]) * ((i % p != 0) ? i : 1) % pk);
    fn = pfree_fact(n, p, pk);
    fm = pfree_fact(m, p, pk);
    fd = pfree_fact(n - m, p, pk);
    e = p_excess(n, p) - p_excess(m, p) - p_excess(n - m, p);
    fn = fn * inv_mod(fm, pk) % pk;
    fn = fn * inv_mod(fd, pk) % pk;
    return fn * pow_mod(p, e, pk) % pk;
  endfunction

  // crt join of one prime power residue into the running result
  function automatic longint unsigned crt_term(longint unsigned a, longint unsigned pk,
                                               longint unsigned md);
    longint unsigned other, t;
    other = md / pk;
    t = a * other % md;
    return t * inv_mod(other % pk, pk) % md;
  endfunction

  function automatic logic [MOD_BITS-1:0] predict_residue(binom_req_t r);
    longint unsigned n, m, md, rest, d, pk, acc;
    n = 64'(r.n);
    m = 64'(r.m);
    md = 64'(r.md);
    acc = 0;
    if (md <= 1 || m > n) return '0;
    rest = md;
    for (d = 2; d * d <= rest && rest > 1; d++) begin
      pk = 1;
      while (rest % d == 0) begin
        pk *= d;
        rest /= d;
      end
      if (pk > 1) acc = (acc + crt_term(binom_prime_pow(n, m, d, pk), pk, md)) % md;
    end
    if (rest > 1) acc = (acc + crt_term(binom_prime_pow(n, m, rest, rest), rest, md)) % md;
    return acc[MOD_BITS-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [MOD_BITS-1:0] got,
                                 logic [MOD_BITS-1:0] want);
    $display("result %0d: %s got %0d want %0d", accepted_results, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [N_BITS-1:0] rand_wide();
    return N_BITS'({$urandom(), $urandom()});
  endfunction

  task automatic add_req(logic [N_BITS-1:0] n, logic [N_BITS-1:0] m,
                         logic [MOD_BITS-1:0] md, bit drain);
    binom_req_t r;
    r.n = n;
    r.m = m;
    r.md = md;
    r.drain = drain;
    pending_reqs.push_back(r);
  endtask

  // request driver
  always @(posedge clk) begin
    binom_req_t r;
    bit steady;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        r.n = n_value;
        r.m = m_value;
        r.md = modulus;
        expected_residues.push_back(predict_residue(r));
        accepted_reqs++;
      end
      steady = (accepted_reqs >= 40 && accepted_reqs < 75);
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 &&
            !(pending_reqs[0].drain && (expected_residues.size() > 0 ||
              (in_valid && in_ready))) &&
            (steady || $urandom_range(0, 99) >= 19)) begin
          r = pending_reqs.pop_front();
          n_value <= r.n;
          m_value <= r.m;
          modulus <= r.md;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    logic [MOD_BITS-1:0] want;
    if (rst) begin
      out_ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_residues.size() == 0) begin
          report_mismatch("residue with no request", residue, 'x);
        end else begin
          want = expected_residues.pop_front();
          if (residue !== want) report_mismatch("residue", residue, want);
        end
        accepted_results++;
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
      out_ready <= (accepted_results >= 40 && accepted_results < 75) ||
                   ($urandom_range(0, 99) >= 19);
    end
  end

  // stimulus and end of run
  initial begin
    logic [N_BITS-1:0] n, m;
    logic [MOD_BITS-1:0] md;
    mismatch_count = 0;
    accepted_reqs = 0;
    accepted_results = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    n_value = '0;
    m_value = '0;
    modulus = '0;

    // directed: trivial cases, extremes, prime powers, composite moduli
    add_req('0, '0, 20'd7, 1'b0);
    add_req(60'd5, 60'd6, 20'd13, 1'b0);
    add_req('1, '1, 20'd1, 1'b0);
    add_req(60'd0, '1, '1, 1'b0);
    add_req('1, 60'd3, 20'd41, 1'b0);
    add_req('1, '1, 20'd41, 1'b0);
    add_req(60'd10, 60'd3, 20'd1, 1'b0);
    add_req(60'd10, 60'd3, 20'd2, 1'b0);
    add_req(60'd10, 60'd5, 20'd8, 1'b0);
    add_req(60'd27, 60'd9, 20'd27, 1'b0);
    add_req(60'd100, 60'd50, 20'd12, 1'b0);
    add_req(60'd100, 60'd37, 20'd30, 1'b0);
    add_req(60'd200, 60'd100, '1, 1'b0);
    add_req(60'd255, 60'd0, 20'd97, 1'b0);
    add_req(60'd255, 60'd255, 20'd64, 1'b0);
    add_req(60'd1000, 60'd500, 20'd210, 1'b0);
    add_req(60'd77, 60'd30, 20'd121, 1'b0);
    add_req(60'd50, 60'd25, 20'd3, 1'b0);

    // random part, the first one and the one at index 50 wait for the block to drain
    for (int i = 0; i < 82; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        // m above n: full-width operands, quick answer
        n = rand_wide();
        m = rand_wide();
        if (m <= n) begin
          m = n;
          if (m == '0) m = N_BITS'(1);
          n = m - N_BITS'(1);
        end
        md = MOD_BITS'($urandom());
        if (md == '0) md = MOD_BITS'(1);
      end else begin
        n = N_BITS'($urandom_range(0, 255));
        m = ($urandom_range(0, 9) == 0) ? n + N_BITS'(1)
                                        : N_BITS'($urandom_range(0, 32'(n)));
        case ($urandom_range(0, 9))
          0: md = '1;
          1: md = MOD_BITS'(1);
          default: md = MOD_BITS'($urandom_range(2, 200));
        endcase
      end
      add_req(n, m, md, i == 0 || i == 50);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || in_valid || expected_residues.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
